// File: src/descriptor_slot_allocator_macros.svh
// assertion macros for the descriptor slot allocator
// every macro samples on clk and is disabled while rst_n is low
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_MACROS_SVH

// condition holds at every clock edge
`define DSA_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DSA_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define DSA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/dsa_pkg.sv
package dsa_pkg;

    // free stack geometry
    localparam int HEAP_DEPTH  = 1024;
    localparam int STACK_AW    = $clog2(HEAP_DEPTH);
    localparam int COUNT_W     = STACK_AW + 1;

    // slot index space
    localparam int INDEX_W     = 10;
    localparam int FRESH_W     = INDEX_W + 1;
    localparam int INDEX_SPACE = 1 << INDEX_W;

    // register widths
    localparam int CAP_W       = 11;
    localparam int STRIDE_W    = 13;
    localparam int ADDR_W      = 64;
    localparam int PROD_W      = INDEX_W + STRIDE_W;
    localparam int CFG_IDX_W   = 2;

    // stream widths
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 144;
    localparam int M_PAYLOAD_W = INDEX_W + 2 * ADDR_W;

    // request codes
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEVER_ALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_STRIDE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE      = 2'd3;

    // configuration reset values
    localparam logic [CAP_W-1:0]    CAP_RESET    = 11'd1024;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd32;

endpackage

// File: src/dsa_ram.sv
module dsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/descriptor_slot_allocator.sv
// sequence: a request is taken in S_IDLE; an allocate that pops the free stack then passes S_READ for
//   the stack memory read; S_MUL registers index times stride and S_ADD registers the result
// S_ADD waits while the result register is still held; no new transaction is taken until S_ADD ends
// reset: rst_n clears the counters and restores heap_capacity 1024, slot_stride 32 and
//   zero bases; the free stack memory is not cleared, entries are read only after a push
module descriptor_slot_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dsa_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // slot_index[9:0], zero pad
    input  logic [dsa_pkg::OP_W-1:0]         s_axis_tuser,  // operation[1:0]
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [dsa_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // granted_index[9:0],
                                                            // cpu_address[73:10],
                                                            // gpu_address[137:74], zero pad
    output logic [dsa_pkg::STATUS_W-1:0]     m_axis_tuser,  // status[1:0]
    // configuration writes
    input  logic                             cfg_we,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsa_pkg::ADDR_W-1:0]       cfg_data
);

    import dsa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_ADD  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CAP_W-1:0]    heap_capacity_reg;
    logic [STRIDE_W-1:0] slot_stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;
    logic [FRESH_W-1:0]  next_fresh_reg, next_fresh_next;
    logic [COUNT_W-1:0]  free_count_reg, free_count_next;
    logic                out_valid_reg, out_valid_next;

    logic [INDEX_W-1:0]  granted_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                give_addr_reg;
    logic [PROD_W-1:0]   product_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [ADDR_W-1:0]   out_cpu_reg;
    logic [ADDR_W-1:0]   out_gpu_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                in_acc;
    logic [OP_W-1:0]     op;
    logic [INDEX_W-1:0]  idx;
    logic                fresh_ok;
    logic                stack_empty;
    logic                stack_full;
    logic                never_alloc;
    logic                no_space_hit;
    logic                out_free;
    logic                out_load;
    logic [INDEX_W-1:0]  issue_index;
    logic [STATUS_W-1:0] issue_status;
    logic                issue_addr;

    logic                ram_we;
    logic                ram_re;
    logic [STACK_AW-1:0] ram_waddr;
    logic [STACK_AW-1:0] ram_raddr;
    logic [INDEX_W-1:0]  ram_rdata;

    // request decode
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign op            = s_axis_tuser;
    assign idx           = s_axis_tdata[INDEX_W-1:0];
    assign fresh_ok      = (next_fresh_reg < heap_capacity_reg)
                        && (next_fresh_reg < FRESH_W'(INDEX_SPACE));
    assign stack_empty   = (free_count_reg == '0);
    assign stack_full    = (free_count_reg == COUNT_W'(HEAP_DEPTH));
    assign never_alloc   = ({1'b0, idx} >= next_fresh_reg);
    assign no_space_hit  = in_acc && (op == OP_ALLOC) && stack_empty && !fresh_ok;

    // output register handoff
    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (state_reg == S_ADD) && out_free;

    // stack addresses: push at the count, pop just below it
    assign ram_waddr = free_count_reg[STACK_AW-1:0];
    assign ram_raddr = STACK_AW'(free_count_reg - COUNT_W'(1));

    // sequencer and allocator state update
    always_comb
    begin
        state_next      = state_reg;
        next_fresh_next = next_fresh_reg;
        free_count_next = free_count_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        issue_index     = '0;
        issue_status    = ST_OK;
        issue_addr      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_MUL;
                    case (op)
                        OP_ALLOC:
                        begin
                            if (!stack_empty)
                            begin
                                free_count_next = free_count_reg - COUNT_W'(1);
                                ram_re          = 1'b1;
                                issue_addr      = 1'b1;
                                state_next      = S_READ;
                            end
                            else if (fresh_ok)
                            begin
                                issue_index     = next_fresh_reg[INDEX_W-1:0];
                                issue_addr      = 1'b1;
                                next_fresh_next = next_fresh_reg + FRESH_W'(1);
                            end
                            else
                            begin
                                issue_status = ST_NO_SPACE;
                            end
                        end
                        OP_FREE:
                        begin
                            issue_index = idx;
                            if (never_alloc)
                            begin
                                issue_status = ST_NEVER_ALLOC;
                            end
                            else if (stack_full)
                            begin
                                issue_status = ST_STACK_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                free_count_next = free_count_reg + COUNT_W'(1);
                            end
                        end
                        OP_LOOKUP:
                        begin
                            issue_index = idx;
                            issue_addr  = 1'b1;
                        end
                        default:
                        begin
                            issue_index = '0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_fresh_reg <= '0;
            free_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_fresh_reg <= next_fresh_next;
            free_count_reg <= free_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_capacity_reg <= CAP_RESET;
            slot_stride_reg   <= STRIDE_RESET;
            cpu_base_reg      <= '0;
            gpu_base_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEAP_CAPACITY: heap_capacity_reg <= cfg_data[CAP_W-1:0];
                CFG_SLOT_STRIDE:   slot_stride_reg   <= cfg_data[STRIDE_W-1:0];
                CFG_CPU_BASE:      cpu_base_reg      <= cfg_data;
                CFG_GPU_BASE:      gpu_base_reg      <= cfg_data;
                default:           cpu_base_reg      <= cpu_base_reg;
            endcase
        end
    end

    // working payload: issue, stack read, index times stride
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            granted_reg   <= issue_index;
            status_reg    <= issue_status;
            give_addr_reg <= issue_addr;
        end
        else if (state_reg == S_READ)
        begin
            granted_reg <= ram_rdata;
        end
        if (state_reg == S_MUL)
        begin
            product_reg <= PROD_W'(granted_reg) * PROD_W'(slot_stride_reg);
        end
    end

    // result payload: base plus offset
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg  <= granted_reg;
            out_status_reg <= status_reg;
            out_cpu_reg    <= give_addr_reg ? cpu_base_reg + ADDR_W'(product_reg) : '0;
            out_gpu_reg    <= give_addr_reg ? gpu_base_reg + ADDR_W'(product_reg) : '0;
        end
    end

    // free stack memory
    dsa_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (HEAP_DEPTH)
    ) u_free_stack (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (idx),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // result stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - M_PAYLOAD_W)'(0), out_gpu_reg, out_cpu_reg,
                            out_index_reg};
    assign m_axis_tuser  = out_status_reg;

`include "descriptor_slot_allocator_macros.svh"

    `DSA_ASSERT_ALWAYS(a_count_bound, free_count_reg <= COUNT_W'(HEAP_DEPTH), "free count overflow")
    `DSA_ASSERT_ALWAYS(a_fresh_bound, next_fresh_reg <= FRESH_W'(INDEX_SPACE), "fresh counter overflow")
    `DSA_ASSERT_NEXT(a_no_space_hold, no_space_hit, $stable(next_fresh_reg) && $stable(free_count_reg), "failed allocate changed state")
    `DSA_ASSERT_SAME(a_pop_count, state_reg == S_READ, $past(free_count_reg) == free_count_reg + COUNT_W'(1), "pop without count decrement")

endmodule
